// File: src/rpp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rpp_pkg
// Shared codes, field widths, structs and helpers of the residual push
// ranking engine.
// ============================================================================
package rpp_pkg;

    // Field widths of the channel words and configuration registers.
    localparam int OP_W    = 2;
    localparam int VTX_W   = 10;
    localparam int RANK_W  = 32;
    localparam int ROUND_W = 16;
    localparam int CFG_W   = 17;
    localparam int CIDX_W  = 2;
    localparam int VCNT_W  = 11;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_THR   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_VCNT  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_CAP   = 2'd3;

    // Request handed from the channel logic to the engine.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] tgt;
    } t_req;

    // Run and load status shown with every result word.
    typedef struct packed {
        logic [ROUND_W-1:0] rounds;
        logic               limit_hit;
        logic               load_err;
    } t_status;

    // Saturating 32-bit add.
    function automatic logic [RANK_W-1:0] sat_add(input logic [RANK_W-1:0] a,
                                                  input logic [RANK_W-1:0] b);
        logic [RANK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[RANK_W] ? {RANK_W{1'b1}} : s[RANK_W-1:0];
    endfunction

endpackage

// File: src/rpp_item_if.sv
`timescale 1ns / 1ps
// ============================================================================
// rpp_item_if
// Input channel: one command word per handshake.
// ============================================================================
interface rpp_item_if;
    logic                      valid;
    logic                      ready;
    logic [rpp_pkg::OP_W-1:0]  op;
    logic [rpp_pkg::VTX_W-1:0] source_vertex;
    logic [rpp_pkg::VTX_W-1:0] target_vertex;

    modport source(output valid, op, source_vertex, target_vertex, input ready);
    modport sink(input valid, op, source_vertex, target_vertex, output ready);
endinterface

// File: src/rpp_result_if.sv
`timescale 1ns / 1ps
// ============================================================================
// rpp_result_if
// Output channel: one result word per handshake.
// ============================================================================
interface rpp_result_if;
    logic                        valid;
    logic                        ready;
    logic [rpp_pkg::RANK_W-1:0]  rank_value;
    logic [rpp_pkg::ROUND_W-1:0] rounds_run;
    logic                        round_limit_hit;
    logic                        load_error;

    modport source(output valid, rank_value, rounds_run, round_limit_hit, load_error,
                   input ready);
    modport sink(input valid, rank_value, rounds_run, round_limit_hit, load_error,
                 output ready);
endinterface

// File: src/rpp_divider.sv
`timescale 1ns / 1ps
// ============================================================================
// rpp_divider
// Restoring divider, one quotient bit per cycle, unsigned.
// ============================================================================
module rpp_divider #(
    parameter int DW = 32,
    parameter int SW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [SW-1:0] r_div;
    logic          r_done;
    logic [SW:0]   rem_sh;
    logic [SW:0]   rem_sub;
    logic          q_bit;

    // One trial subtraction per step.
    always_comb begin
        rem_sh  = {r_rem, r_quo[DW-1]};
        q_bit   = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
                r_rem <= '0;
                r_quo <= i_dividend;
                r_div <= i_divisor;
            end else if (r_cnt != '0) begin
                r_rem  <= q_bit ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
                r_quo  <= {r_quo[DW-2:0], q_bit};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CW'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// File: src/rpp_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// rpp_engine
// Graph and vertex memories with the load, run and read sequencer.
// ============================================================================
module rpp_engine #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_EDGES     = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rpp_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [rpp_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_start,
    input  rpp_pkg::t_req                i_req,
    output logic                         o_idle,
    output logic                         o_drop,
    output logic                         o_done,
    output logic [rpp_pkg::RANK_W-1:0]   o_rank,
    output rpp_pkg::t_status             o_status
);
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int GW  = 2 * EW;
    localparam int RW  = rpp_pkg::RANK_W;
    localparam logic [RW-1:0] ONE_FIX = RW'(1) << FRACTION_BITS;

    localparam logic [3:0] S_DCLR   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_RCLR   = 4'd3;
    localparam logic [3:0] S_VLOAD  = 4'd4;
    localparam logic [3:0] S_VWAIT  = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_DIVS   = 4'd7;
    localparam logic [3:0] S_DIVW   = 4'd8;
    localparam logic [3:0] S_EREAD  = 4'd9;
    localparam logic [3:0] S_TREAD  = 4'd10;
    localparam logic [3:0] S_TWRITE = 4'd11;
    localparam logic [3:0] S_NEXT   = 4'd12;

    localparam logic [1:0] P_INIT  = 2'd0;
    localparam logic [1:0] P_FIRST = 2'd1;
    localparam logic [1:0] P_ROUND = 2'd2;

    // Configuration registers.
    logic [rpp_pkg::CFG_W-1:0]   r_alpha;
    logic [rpp_pkg::CFG_W-1:0]   r_thr;
    logic [rpp_pkg::VCNT_W-1:0]  r_vcount;
    logic [rpp_pkg::ROUND_W-1:0] r_cap;

    // Memories.
    logic [rpp_pkg::VTX_W-1:0] m_edge  [MAX_EDGES];
    logic [GW-1:0]             m_graph [MAX_VERTICES];
    logic [RW-1:0]             m_rank  [MAX_VERTICES];
    logic [RW-1:0]             m_res   [MAX_VERTICES];

    logic [rpp_pkg::VTX_W-1:0] r_edge_q;
    logic [GW-1:0]             r_graph_q;
    logic [RW-1:0]             r_rank_q;
    logic [RW-1:0]             r_res_q;

    // Control and datapath registers.
    logic [3:0]                  r_state;
    logic [1:0]                  r_phase;
    logic [VCW-1:0]              r_v;
    logic                        r_active;
    logic [rpp_pkg::ROUND_W-1:0] r_rounds;
    logic                        r_limit;
    logic                        r_lerr;
    logic [EW-1:0]               r_loaded;
    logic [rpp_pkg::VTX_W-1:0]   r_last;
    logic [EW-1:0]               r_cur_deg;
    logic [EW-1:0]               r_cur_first;
    logic                        r_ran;
    logic [VCW-1:0]              r_run_n;
    logic                        r_rd_ok;
    logic                        r_done;
    logic [RW-1:0]               r_rank;
    logic [RW-1:0]               r_amount;
    logic [2*RW-1:0]             r_prod;
    logic [RW-1:0]               r_delta;
    logic [EW-1:0]               r_deg;
    logic [EW-1:0]               r_first;
    logic [EW-1:0]               r_e;
    logic [EW-1:0]               r_k;
    logic [VW-1:0]               r_t;

    // Effective run settings.
    logic [RW-1:0]               alpha_eff;
    logic [RW-1:0]               thr_eff;
    logic [31:0]                 vc32;
    logic [VCW-1:0]              n_eff;
    logic [rpp_pkg::ROUND_W-1:0] cap_eff;

    always_comb begin
        alpha_eff = (RW'(r_alpha) > ONE_FIX) ? ONE_FIX : RW'(r_alpha);
        thr_eff   = RW'(r_thr);
        vc32      = 32'(r_vcount);
        if (vc32 == 32'd0) begin
            n_eff = VCW'(1);
        end else if (vc32 > 32'(MAX_VERTICES)) begin
            n_eff = VCW'(MAX_VERTICES);
        end else begin
            n_eff = vc32[VCW-1:0];
        end
        cap_eff = (r_cap == '0) ? rpp_pkg::ROUND_W'(1) : r_cap;
    end

    // Request decode.
    logic [31:0]   src32;
    logic [31:0]   tgt32;
    logic [31:0]   et32;
    logic [VW-1:0] s_addr;
    logic [VW-1:0] v_addr;
    logic [VW-1:0] et_addr;
    logic          in_idle_req;
    logic          is_load;
    logic          dropped;
    logic          new_src;
    logic [EW-1:0] deg_new;
    logic [EW-1:0] first_new;
    logic          et_in_run;

    always_comb begin
        src32       = 32'(i_req.src);
        tgt32       = 32'(i_req.tgt);
        et32        = 32'(r_edge_q);
        s_addr      = src32[VW-1:0];
        v_addr      = r_v[VW-1:0];
        et_addr     = et32[VW-1:0];
        et_in_run   = (et32 < 32'(n_eff));
        in_idle_req = i_start && (r_state == S_IDLE);
        is_load     = in_idle_req && (i_req.op == rpp_pkg::OP_LOAD);
        dropped     = (32'(r_loaded) >= 32'(MAX_EDGES)) ||
                      (src32 >= 32'(MAX_VERTICES)) || (tgt32 >= 32'(MAX_VERTICES)) ||
                      ((r_loaded != '0) && (i_req.src < r_last));
        new_src     = (r_loaded == '0) || (i_req.src != r_last);
        deg_new     = new_src ? EW'(1) : r_cur_deg + 1'b1;
        first_new   = new_src ? r_loaded : r_cur_first;
    end

    // Vertex decision on the read-back words.
    logic [EW-1:0] q_deg;
    logic [EW-1:0] q_first;
    logic          acts;
    logic [RW-1:0] amount;

    always_comb begin
        q_deg   = r_graph_q[EW-1:0];
        q_first = r_graph_q[GW-1:EW];
        acts    = (r_phase != P_ROUND) || (r_res_q > thr_eff);
        amount  = (r_phase == P_INIT) ? (ONE_FIX - alpha_eff) : r_res_q;
    end

    // Memory write ports and read addresses.
    logic                      edge_we;
    logic [EAW-1:0]            edge_wa;
    logic                      graph_we;
    logic [VW-1:0]             graph_wa;
    logic [GW-1:0]             graph_wd;
    logic                      rank_we;
    logic [RW-1:0]             rank_wd;
    logic [VW-1:0]             rank_ra;
    logic                      res_we;
    logic [VW-1:0]             res_wa;
    logic [RW-1:0]             res_wd;
    logic [VW-1:0]             res_ra;

    always_comb begin
        edge_we  = is_load && !dropped;
        edge_wa  = r_loaded[EAW-1:0];
        graph_we = 1'b0;
        graph_wa = v_addr;
        graph_wd = '0;
        if (r_state == S_DCLR) begin
            graph_we = 1'b1;
        end else if (is_load && !dropped) begin
            graph_we = 1'b1;
            graph_wa = s_addr;
            graph_wd = {first_new, deg_new};
        end
        rank_we = (r_state == S_VWAIT) && acts;
        rank_wd = (r_phase == P_INIT) ? amount : rpp_pkg::sat_add(r_rank_q, r_res_q);
        rank_ra = (r_state == S_IDLE) ? s_addr : v_addr;
        res_we  = 1'b0;
        res_wa  = v_addr;
        res_wd  = '0;
        case (r_state)
            S_RCLR: begin
                res_we = 1'b1;
            end
            S_VWAIT: begin
                res_we = (r_phase != P_INIT);
            end
            S_TWRITE: begin
                res_we = 1'b1;
                res_wa = r_t;
                res_wd = rpp_pkg::sat_add(r_res_q, r_delta);
            end
            default: begin
                res_we = 1'b0;
            end
        endcase
        res_ra = (r_state == S_TREAD) ? et_addr : v_addr;
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            m_edge[edge_wa] <= i_req.tgt;
        end
        r_edge_q <= m_edge[r_e[EAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (graph_we) begin
            m_graph[graph_wa] <= graph_wd;
        end
        r_graph_q <= m_graph[v_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            m_rank[v_addr] <= rank_wd;
        end
        r_rank_q <= m_rank[rank_ra];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            m_res[res_wa] <= res_wd;
        end
        r_res_q <= m_res[res_ra];
    end

    // Share divider for the per-edge delta.
    logic          div_start;
    logic          div_done;
    logic [RW-1:0] div_quot;

    assign div_start = (r_state == S_DIVS);

    rpp_divider #(
        .DW (RW),
        .SW (EW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod[FRACTION_BITS+RW-1:FRACTION_BITS]),
        .i_divisor  (r_deg),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= rpp_pkg::CFG_W'(9830);
            r_thr    <= rpp_pkg::CFG_W'(655);
            r_vcount <= rpp_pkg::VCNT_W'(1024);
            r_cap    <= rpp_pkg::ROUND_W'(1023);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpp_pkg::CFG_ALPHA: r_alpha  <= i_cfg_data;
                rpp_pkg::CFG_THR:   r_thr    <= i_cfg_data;
                rpp_pkg::CFG_VCNT:  r_vcount <= i_cfg_data[rpp_pkg::VCNT_W-1:0];
                rpp_pkg::CFG_CAP:   r_cap    <= i_cfg_data[rpp_pkg::ROUND_W-1:0];
                default:            r_cap    <= r_cap;
            endcase
        end
    end

    // Last-edge, last-vertex and next round count tests used by the sequencer.
    logic          last_edge;
    logic          v_last;
    logic [rpp_pkg::ROUND_W-1:0] rounds_new;

    assign last_edge  = (r_k == EW'(1));
    assign v_last     = ((r_v + 1'b1) == n_eff);
    assign rounds_new = r_rounds + 1'b1;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_DCLR;
            r_phase  <= P_INIT;
            r_v      <= '0;
            r_active <= 1'b0;
            r_rounds <= '0;
            r_limit  <= 1'b0;
            r_lerr   <= 1'b0;
            r_loaded <= '0;
            r_last   <= '0;
            r_cur_deg   <= '0;
            r_cur_first <= '0;
            r_ran    <= 1'b0;
            r_run_n  <= '0;
            r_rd_ok  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_DCLR: begin
                    // Degree clearing sweep after reset.
                    if (r_v == VCW'(MAX_VERTICES - 1)) begin
                        r_v     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        case (i_req.op)
                            rpp_pkg::OP_LOAD: begin
                                if (dropped) begin
                                    r_lerr <= 1'b1;
                                end else begin
                                    r_loaded    <= r_loaded + 1'b1;
                                    r_last      <= i_req.src;
                                    r_cur_deg   <= deg_new;
                                    r_cur_first <= first_new;
                                end
                            end
                            rpp_pkg::OP_RUN: begin
                                r_v      <= '0;
                                r_phase  <= P_INIT;
                                r_rounds <= '0;
                                r_active <= 1'b0;
                                r_state  <= S_RCLR;
                            end
                            rpp_pkg::OP_READ: begin
                                r_rd_ok <= r_ran && (src32 < 32'(MAX_VERTICES)) &&
                                           (src32 < 32'(r_run_n));
                                r_state <= S_READ;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_done  <= 1'b1;
                    r_rank  <= r_rd_ok ? r_rank_q : '0;
                    r_state <= S_IDLE;
                end
                S_RCLR: begin
                    // Residual clearing over the vertices in use.
                    if (v_last) begin
                        r_v     <= '0;
                        r_state <= S_VLOAD;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_VLOAD: begin
                    r_state <= S_VWAIT;
                end
                S_VWAIT: begin
                    if (acts && (q_deg != '0)) begin
                        r_active <= 1'b1;
                        r_amount <= amount;
                        r_deg    <= q_deg;
                        r_first  <= q_first;
                        r_state  <= S_MUL;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_amount * alpha_eff;
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_delta <= div_quot;
                        r_e     <= r_first;
                        r_k     <= r_deg;
                        r_state <= S_EREAD;
                    end
                end
                S_EREAD: begin
                    r_state <= S_TREAD;
                end
                S_TREAD: begin
                    // Targets outside the run lose their share.
                    if (et_in_run) begin
                        r_t     <= et_addr;
                        r_state <= S_TWRITE;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_k     <= r_k - 1'b1;
                        r_state <= last_edge ? S_NEXT : S_EREAD;
                    end
                end
                S_TWRITE: begin
                    r_e     <= r_e + 1'b1;
                    r_k     <= r_k - 1'b1;
                    r_state <= last_edge ? S_NEXT : S_EREAD;
                end
                S_NEXT: begin
                    if (!v_last) begin
                        r_v     <= r_v + 1'b1;
                        r_state <= S_VLOAD;
                    end else begin
                        r_v <= '0;
                        case (r_phase)
                            P_INIT: begin
                                r_phase <= P_FIRST;
                                r_state <= S_VLOAD;
                            end
                            P_FIRST: begin
                                r_phase  <= P_ROUND;
                                r_active <= 1'b0;
                                r_state  <= S_VLOAD;
                            end
                            default: begin
                                r_rounds <= rounds_new;
                                if (r_active && (rounds_new < cap_eff)) begin
                                    r_active <= 1'b0;
                                    r_state  <= S_VLOAD;
                                end else begin
                                    r_limit <= r_active;
                                    r_ran   <= 1'b1;
                                    r_run_n <= n_eff;
                                    r_done  <= 1'b1;
                                    r_rank  <= '0;
                                    r_state <= S_IDLE;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_drop   = is_load && dropped;
    assign o_done   = r_done;
    assign o_rank   = r_rank;
    assign o_status = '{rounds: r_rounds, limit_hit: r_limit, load_err: r_lerr};
endmodule

// File: src/residual_pagerank_push_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// residual_pagerank_push_engine
// Residual push ranking over a loaded directed graph, Q16.16 fixed point.
// ============================================================================
// Usage: commands enter on i_item (op, source_vertex, target_vertex) and
// every command except op 3 returns one word on o_result carrying the rank
// (reads only), the round count of the last run and the two flags.
// Edge loads can stream back to back while the receiver takes each word;
// the result word appears in the output register on the next cycle. A rank
// read passes its word through the rank memory, the sequencer and the
// output register, and the next command can be taken as that word leaves.
// A run walks every vertex in use once per pass: each vertex is read and
// tested, each pushing vertex waits on the shared serial divider, and each
// edge does a read-modify-write of its target's residual. The run does an
// init pass, a full pass and then convergence rounds.
// After reset the degree memory is swept clear, and no command is accepted
// during the sweep; configuration writes are taken at any time. A command
// is accepted only while the sequencer is idle, no word is being handed
// over and the output register is empty or being emptied, so a stalled
// receiver holds the result word and stalls the input.
module residual_pagerank_push_engine #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_EDGES     = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rpp_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [rpp_pkg::CFG_W-1:0]  i_cfg_data,
    rpp_item_if.sink                   i_item,
    rpp_result_if.source               o_result
);
    logic                       eng_idle;
    logic                       eng_drop;
    logic                       eng_done;
    logic [rpp_pkg::RANK_W-1:0] eng_rank;
    rpp_pkg::t_status           eng_status;
    rpp_pkg::t_req              req;
    logic                       out_free;
    logic                       accept;

    logic                        r_out_valid;
    logic [rpp_pkg::RANK_W-1:0]  r_out_rank;
    rpp_pkg::t_status            r_out_status;

    // Input handshake; a finishing run or read owns the output register.
    assign out_free     = !r_out_valid || o_result.ready;
    assign i_item.ready = eng_idle && out_free && !eng_done;
    assign accept       = i_item.valid && i_item.ready;
    assign req          = '{op: i_item.op, src: i_item.source_vertex,
                            tgt: i_item.target_vertex};

    rpp_engine #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_EDGES     (MAX_EDGES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_start    (accept),
        .i_req      (req),
        .o_idle     (eng_idle),
        .o_drop     (eng_drop),
        .o_done     (eng_done),
        .o_rank     (eng_rank),
        .o_status   (eng_status)
    );

    // Output word register: loads report at once, runs and reads on done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && (i_item.op == rpp_pkg::OP_LOAD)) begin
            r_out_valid  <= 1'b1;
            r_out_rank   <= '0;
            r_out_status <= '{rounds: eng_status.rounds,
                              limit_hit: eng_status.limit_hit,
                              load_err: eng_status.load_err | eng_drop};
        end else if (eng_done) begin
            r_out_valid  <= 1'b1;
            r_out_rank   <= eng_rank;
            r_out_status <= eng_status;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.rank_value      = r_out_rank;
    assign o_result.rounds_run      = r_out_status.rounds;
    assign o_result.round_limit_hit = r_out_status.limit_hit;
    assign o_result.load_error      = r_out_status.load_err;
endmodule
